// ===== rtl/wsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveshaping compander package
// Shared constants and the item classification code used by front and back.
// ----------------------------------------------------------------------------
package wsc_pkg;

  localparam int unsigned TablePointsDef = 512;
  localparam int unsigned SampleBitsDef  = 16;
  localparam int unsigned IndexBits      = 9;
  localparam int unsigned ValueBits      = 16;
  localparam int unsigned GainBits       = 17;  // unsigned Q5.12
  localparam int unsigned GainFracBits   = 12;
  localparam int unsigned QueueDepth     = 4;   // power of two

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [2:0] {
    KIND_PASS  = 3'b001,
    KIND_SHAPE = 3'b010,
    KIND_WRITE = 3'b100
  } kind_e;

endpackage

// ===== rtl/wsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compander front end
// Accepts input beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module wsc_front import wsc_pkg::*; #(
  parameter int unsigned SampleBits  = SampleBitsDef,
  parameter int unsigned TablePoints = TablePointsDef,
  localparam int unsigned AddrBits   = $clog2(TablePoints)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         op_i,
  input  logic signed [SampleBits-1:0] sample_re_i,
  input  logic signed [SampleBits-1:0] sample_im_i,
  input  logic [IndexBits-1:0]         table_index_i,
  input  logic [ValueBits-1:0]         table_value_i,
  input  logic                         enable_i,
  input  logic                         q_pop_i,
  output logic                         q_empty_o,
  output kind_e                        kind_o,
  output logic signed [SampleBits-1:0] re_o,
  output logic signed [SampleBits-1:0] im_o,
  output logic [AddrBits-1:0]          addr_o,
  output logic [ValueBits-1:0]         value_o
);

  localparam int unsigned CmpBits = ((AddrBits > IndexBits) ? AddrBits : IndexBits) + 1;
  localparam int unsigned PtrBits = $clog2(QueueDepth);

  typedef struct packed {
    kind_e                         kind;
    logic signed [SampleBits-1:0]  re;
    logic signed [SampleBits-1:0]  im;
    logic [AddrBits-1:0]           addr;
    logic [ValueBits-1:0]          value;
  } entry_t;

  entry_t              q_mem_q [QueueDepth];
  entry_t              entry;
  entry_t              head;
  logic [PtrBits-1:0]  wptr_q, rptr_q;
  logic [PtrBits:0]    count_q;
  logic [CmpBits-1:0]  index_ext;
  logic                keep;
  logic                wr_en;

  always_comb begin
    index_ext   = CmpBits'(table_index_i);
    entry.re    = sample_re_i;
    entry.im    = sample_im_i;
    entry.addr  = AddrBits'(index_ext);
    entry.value = table_value_i;
    keep        = 1'b1;
    if (op_i == OP_WRITE) begin
      entry.kind = KIND_WRITE;
      // writes beyond the table are taken and dropped
      keep       = (index_ext < CmpBits'(TablePoints));
    end else if (enable_i) begin
      entry.kind = KIND_SHAPE;
    end else begin
      entry.kind = KIND_PASS;
    end
  end

  assign full      = (count_q == (PtrBits+1)'(QueueDepth));
  assign q_empty_o = (count_q == '0);
  assign wr_en     = push && !full && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_en) begin
        wptr_q <= wptr_q + PtrBits'(1);
      end
      if (q_pop_i) begin
        rptr_q <= rptr_q + PtrBits'(1);
      end
      if (wr_en && !q_pop_i) begin
        count_q <= count_q + (PtrBits+1)'(1);
      end else if (!wr_en && q_pop_i) begin
        count_q <= count_q - (PtrBits+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem_q[wptr_q] <= entry;
    end
  end

  assign head    = q_mem_q[rptr_q];
  assign kind_o  = head.kind;
  assign re_o    = head.re;
  assign im_o    = head.im;
  assign addr_o  = head.addr;
  assign value_o = head.value;

endmodule

// ===== rtl/wsc_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor of the square root.
// ----------------------------------------------------------------------------
module wsc_sqrt #(
  parameter int unsigned RootBits = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [2*RootBits-1:0]   rad_i,
  output logic [RootBits-1:0]     root_o
);

  localparam int unsigned RemBits = RootBits + 3;

  logic [RemBits-1:0]    rem_q  [RootBits];
  logic [RootBits-1:0]   root_q [RootBits];
  logic [2*RootBits-1:0] rad_q  [RootBits];
  logic [RemBits-1:0]    rem_d  [RootBits];
  logic [RootBits-1:0]   root_d [RootBits];
  logic [2*RootBits-1:0] rad_d  [RootBits];

  always_comb begin
    logic [RemBits-1:0]    rem_in;
    logic [RemBits-1:0]    rem_sh;
    logic [RemBits-1:0]    trial;
    logic [RootBits-1:0]   root_in;
    logic [2*RootBits-1:0] rad_in;
    for (int k = 0; k < RootBits; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad_i;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        rad_in  = rad_q[k-1];
      end
      // bring down the next two radicand bits, try root*4+1
      rem_sh   = {rem_in[RemBits-3:0], rad_in[2*RootBits-1 -: 2]};
      trial    = RemBits'({root_in, 2'b01});
      rad_d[k] = rad_in << 2;
      if (rem_sh >= trial) begin
        rem_d[k]  = rem_sh - trial;
        root_d[k] = {root_in[RootBits-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_sh;
        root_d[k] = {root_in[RootBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RootBits; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
    end
  end

  assign root_o = root_q[RootBits-1];

endmodule

// ===== rtl/wsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Range check stage, then one quotient bit per stage (restoring division).
// ----------------------------------------------------------------------------
module wsc_div #(
  parameter int unsigned DividendBits = 31,
  parameter int unsigned DivisorBits  = 19,
  parameter int unsigned QuotBits     = 17
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [DividendBits-1:0] dividend_i,
  input  logic [DivisorBits-1:0]  divisor_i,
  output logic [QuotBits-1:0]     quot_o,
  output logic                    ovf_o
);

  localparam int unsigned WideBits =
    ((DividendBits > DivisorBits + QuotBits) ? DividendBits : DivisorBits + QuotBits) + 1;
  localparam int unsigned Stages = QuotBits + 1;

  logic [WideBits-1:0]    rem_q  [Stages];
  logic [DivisorBits-1:0] dsr_q  [Stages];
  logic [QuotBits-1:0]    quot_q [Stages];
  logic                   ovf_q  [Stages];
  logic [WideBits-1:0]    rem_d  [Stages];
  logic [DivisorBits-1:0] dsr_d  [Stages];
  logic [QuotBits-1:0]    quot_d [Stages];
  logic                   ovf_d  [Stages];

  always_comb begin
    logic [WideBits-1:0] shifted;
    for (int k = 0; k < Stages; k++) begin
      if (k == 0) begin
        // quotient would not fit: saturate (also catches a zero divisor)
        shifted   = WideBits'(divisor_i) << QuotBits;
        ovf_d[k]  = (WideBits'(dividend_i) >= shifted);
        rem_d[k]  = WideBits'(dividend_i);
        dsr_d[k]  = divisor_i;
        quot_d[k] = '0;
      end else begin
        shifted   = WideBits'(dsr_q[k-1]) << (QuotBits - k);
        ovf_d[k]  = ovf_q[k-1];
        dsr_d[k]  = dsr_q[k-1];
        if (rem_q[k-1] >= shifted) begin
          rem_d[k]  = rem_q[k-1] - shifted;
          quot_d[k] = quot_q[k-1] | (QuotBits'(1) << (QuotBits - k));
        end else begin
          rem_d[k]  = rem_q[k-1];
          quot_d[k] = quot_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Stages; k++) begin
        rem_q[k]  <= rem_d[k];
        dsr_q[k]  <= dsr_d[k];
        quot_q[k] <= quot_d[k];
        ovf_q[k]  <= ovf_d[k];
      end
    end
  end

  assign ovf_o  = ovf_q[Stages-1];
  assign quot_o = ovf_q[Stages-1] ? '1 : quot_q[Stages-1];

endmodule

// ===== rtl/wsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compander back end
// Magnitude, table lookup with interpolation, gain division, scaling and
// the output register. The whole pipe advances whenever the output is free.
// ----------------------------------------------------------------------------
module wsc_back import wsc_pkg::*; #(
  parameter int unsigned SampleBits  = SampleBitsDef,
  parameter int unsigned TablePoints = TablePointsDef,
  localparam int unsigned AddrBits   = $clog2(TablePoints)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  input  kind_e                        kind_i,
  input  logic signed [SampleBits-1:0] re_i,
  input  logic signed [SampleBits-1:0] im_i,
  input  logic [AddrBits-1:0]          addr_i,
  input  logic [ValueBits-1:0]         value_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic signed [SampleBits-1:0] out_re_o,
  output logic signed [SampleBits-1:0] out_im_o,
  output logic                         saturated_o
);

  localparam int unsigned FracBits = SampleBits - 1;
  localparam int unsigned PBits    = SampleBits + $clog2(TablePoints + 1);
  localparam int unsigned IBits    = PBits - FracBits;
  localparam int unsigned MBits    = SampleBits + ValueBits + 1;
  localparam int unsigned YBits    = ValueBits + FracBits;
  localparam int unsigned DBits    = SampleBits + 3;
  localparam int unsigned PrBits   = SampleBits + GainBits + 1;
  // stage positions along the pipe
  localparam int unsigned SqrtDone = 2 + SampleBits;
  localparam int unsigned IdxSt    = SqrtDone + 1;
  localparam int unsigned RdSt     = SqrtDone + 2;
  localparam int unsigned MulSt    = SqrtDone + 3;
  localparam int unsigned YSt      = SqrtDone + 4;
  localparam int unsigned GainSt   = YSt + GainBits + 1;
  localparam int unsigned ProdSt   = GainSt + 1;
  localparam int unsigned Stages   = ProdSt + 1;

  localparam logic signed [PrBits-1:0] SatHi =
    signed'((PrBits'(1) << FracBits) - PrBits'(1));
  localparam logic signed [PrBits-1:0] SatLo = ~SatHi;

  typedef struct packed {
    kind_e                         kind;
    logic signed [SampleBits-1:0]  re;
    logic signed [SampleBits-1:0]  im;
    logic [AddrBits-1:0]           addr;
    logic [ValueBits-1:0]          value;
    logic                          zero;
    logic [SampleBits-1:0]         mag;
  } side_t;

  logic                 adv;
  logic [Stages-1:0]    vld_q;
  side_t                sb_q [Stages];
  side_t                sb_d [Stages];

  logic                 out_valid_q;
  logic signed [SampleBits-1:0] out_re_q, out_im_q;
  logic                 out_sat_q;

  // ---- pipe control -------------------------------------------------------
  assign adv     = !out_valid_q || pop_i;
  assign q_pop_o = adv && !q_empty_i;
  assign empty_o = !out_valid_q;

  logic [SampleBits-1:0] root;

  always_comb begin
    sb_d[0].kind  = kind_i;
    sb_d[0].re    = re_i;
    sb_d[0].im    = im_i;
    sb_d[0].addr  = addr_i;
    sb_d[0].value = value_i;
    sb_d[0].zero  = 1'b0;
    sb_d[0].mag   = '0;
    for (int k = 1; k < Stages; k++) begin
      sb_d[k] = sb_q[k-1];
    end
    sb_d[IdxSt].mag  = root;
    sb_d[IdxSt].zero = (root == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], q_pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < Stages; k++) begin
        sb_q[k] <= sb_d[k];
      end
    end
  end

  // ---- magnitude ----------------------------------------------------------
  logic signed [2*SampleBits-1:0] re_w, im_w;
  logic [2*SampleBits-1:0]        sq_re_q, sq_im_q, sum_q;

  assign re_w = (2*SampleBits)'(sb_q[0].re);
  assign im_w = (2*SampleBits)'(sb_q[0].im);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_re_q <= re_w * re_w;
      sq_im_q <= im_w * im_w;
      sum_q   <= sq_re_q + sq_im_q;
    end
  end

  wsc_sqrt #(
    .RootBits (SampleBits)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sum_q),
    .root_o (root)
  );

  // ---- table position -----------------------------------------------------
  logic [PBits-1:0]    pos;
  logic [IBits-1:0]    seg;
  logic [AddrBits-1:0] ia_q, ib_q;
  logic [FracBits-1:0] frac_q, frac_rd_q;

  assign pos = PBits'(root) * PBits'(TablePoints);
  assign seg = IBits'(pos >> FracBits);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (seg >= IBits'(TablePoints - 1)) begin
        // at or past the last point: last entry, no interpolation
        ia_q   <= AddrBits'(TablePoints - 1);
        ib_q   <= AddrBits'(TablePoints - 1);
        frac_q <= '0;
      end else begin
        ia_q   <= AddrBits'(seg);
        ib_q   <= AddrBits'(seg + IBits'(1));
        frac_q <= pos[FracBits-1:0];
      end
    end
  end

  // ---- transfer table -----------------------------------------------------
  logic [ValueBits-1:0] tbl_mem [TablePoints];
  logic [ValueBits-1:0] ta_q, tb_q, a_mul_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (vld_q[IdxSt] && sb_q[IdxSt].kind == KIND_WRITE) begin
        tbl_mem[sb_q[IdxSt].addr] <= sb_q[IdxSt].value;
      end
      ta_q      <= tbl_mem[ia_q];
      tb_q      <= tbl_mem[ib_q];
      frac_rd_q <= frac_q;
    end
  end

  // ---- interpolation ------------------------------------------------------
  logic signed [MBits-1:0] frac_w, diff_w, interp_q, y_w;
  logic [YBits-1:0]        y_q;

  assign frac_w = MBits'(frac_rd_q);
  assign diff_w = MBits'(tb_q) - MBits'(ta_q);
  assign y_w    = signed'(MBits'(a_mul_q) << FracBits) + interp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      interp_q <= frac_w * diff_w;
      a_mul_q  <= ta_q;
      y_q      <= YBits'(y_w);
    end
  end

  // ---- gain = y / (8 m) ---------------------------------------------------
  logic [GainBits-1:0] gain, gain_eff;
  logic                gain_ovf;

  wsc_div #(
    .DividendBits (YBits),
    .DivisorBits  (DBits),
    .QuotBits     (GainBits)
  ) u_div (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (y_q),
    .divisor_i  ({sb_q[YSt].mag, 3'b000}),
    .quot_o     (gain),
    .ovf_o      (gain_ovf)
  );

  // ---- scaling ------------------------------------------------------------
  logic signed [PrBits-1:0] g_w, sre_w, sim_w, pr_re_q, pr_im_q;
  logic signed [PrBits-1:0] sh_re, sh_im;
  logic                     gsat_q;
  logic signed [SampleBits-1:0] clip_re, clip_im;
  logic                     hit_re, hit_im;

  assign gain_eff = sb_q[GainSt].zero ? '0 : gain;
  assign g_w      = PrBits'(gain_eff);
  assign sre_w    = PrBits'(sb_q[GainSt].re);
  assign sim_w    = PrBits'(sb_q[GainSt].im);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_re_q <= sre_w * g_w;
      pr_im_q <= sim_w * g_w;
      gsat_q  <= gain_ovf && !sb_q[GainSt].zero;
    end
  end

  // floor division by 4096 is an arithmetic shift
  assign sh_re = pr_re_q >>> GainFracBits;
  assign sh_im = pr_im_q >>> GainFracBits;

  always_comb begin
    hit_re  = 1'b1;
    hit_im  = 1'b1;
    if (sh_re > SatHi) begin
      clip_re = SampleBits'(SatHi);
    end else if (sh_re < SatLo) begin
      clip_re = SampleBits'(SatLo);
    end else begin
      clip_re = SampleBits'(sh_re);
      hit_re  = 1'b0;
    end
    if (sh_im > SatHi) begin
      clip_im = SampleBits'(SatHi);
    end else if (sh_im < SatLo) begin
      clip_im = SampleBits'(SatLo);
    end else begin
      clip_im = SampleBits'(sh_im);
      hit_im  = 1'b0;
    end
  end

  // ---- output register ----------------------------------------------------
  logic out_load;
  assign out_load = adv && vld_q[ProdSt] && (sb_q[ProdSt].kind != KIND_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[ProdSt] && (sb_q[ProdSt].kind != KIND_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (sb_q[ProdSt].kind == KIND_PASS) begin
        out_re_q  <= sb_q[ProdSt].re;
        out_im_q  <= sb_q[ProdSt].im;
        out_sat_q <= 1'b0;
      end else begin
        out_re_q  <= clip_re;
        out_im_q  <= clip_im;
        out_sat_q <= gsat_q || hit_re || hit_im;
      end
    end
  end

  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign saturated_o = out_sat_q;

endmodule

// ===== rtl/waveshaping_compander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveshaping compander
// Table driven magnitude compander for complex I/Q samples.
// ----------------------------------------------------------------------------
// Takes one beat per clock while not full: either a signed I/Q sample or a
// write of one transfer table word (table words must be loaded before any
// sample reads them; there is no clearing pass after reset). Each sample is
// scaled by table(|x|)/|x| with linear interpolation between table points,
// the gain held in unsigned Q5.12; results come back in input order, one
// per sample, none for table writes. Throughput is one beat per cycle with
// no bubbles while results are popped; the pipe depth is set by the
// bit-per-stage square root (SAMPLE_BITS stages) and the 18-stage gain
// divider. A four-beat queue sits between the input side and the pipe; the
// pipe freezes as a whole only while a result waits un-popped.
// The enable register may only be written while the block is drained.
// ----------------------------------------------------------------------------
module waveshaping_compander import wsc_pkg::*; #(
  parameter int unsigned TABLE_POINTS = TablePointsDef,
  parameter int unsigned SAMPLE_BITS  = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue side
  input  logic                          push,
  output logic                          full,
  input  logic                          op_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  input  logic [IndexBits-1:0]          table_index_i,
  input  logic [ValueBits-1:0]          table_value_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] out_re_o,
  output logic signed [SAMPLE_BITS-1:0] out_im_o,
  output logic                          saturated_o,
  // enable register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);

  localparam int unsigned AddrBits = $clog2(TABLE_POINTS);

  // compand_enable: beats are classified against it on entry
  logic enable_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_data_i;
    end
  end

  // front to back queue head
  logic                          q_empty, q_pop;
  kind_e                         q_kind;
  logic signed [SAMPLE_BITS-1:0] q_re, q_im;
  logic [AddrBits-1:0]           q_addr;
  logic [ValueBits-1:0]          q_value;

  wsc_front #(
    .SampleBits  (SAMPLE_BITS),
    .TablePoints (TABLE_POINTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .sample_re_i   (sample_re_i),
    .sample_im_i   (sample_im_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .enable_i      (enable_q),
    .q_pop_i       (q_pop),
    .q_empty_o     (q_empty),
    .kind_o        (q_kind),
    .re_o          (q_re),
    .im_o          (q_im),
    .addr_o        (q_addr),
    .value_o       (q_value)
  );

  wsc_back #(
    .SampleBits  (SAMPLE_BITS),
    .TablePoints (TABLE_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .kind_i      (q_kind),
    .re_i        (q_re),
    .im_i        (q_im),
    .addr_i      (q_addr),
    .value_i     (q_value),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .saturated_o (saturated_o)
  );

  // ---- checks -------------------------------------------------------------
  // the back end never drains a queue with nothing in it
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // a full queue always has a head beat to offer
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !q_empty)
    else $error("queue full but head empty");

  // an enable write lands in the register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (enable_q == $past(cfg_data_i)))
    else $error("enable register write lost");

endmodule

// ===== test/waveshaping_compander_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveshaping compander testbench
// Loads the transfer table, then streams directed and random I/Q beats and
// checks each result against an in-order compander predictor.
// ----------------------------------------------------------------------------
// The whole table is written first, so no sample ever reads an unwritten
// word. The run then goes through the enable on and off, with idle bursts on
// both sides, one long receiver hold that backs the block up, table rewrites
// between samples, and a calm final stretch with no idling at all.
// ----------------------------------------------------------------------------
module waveshaping_compander_tb;
  import wsc_pkg::*;

  localparam int unsigned Points    = TablePointsDef;
  localparam int unsigned SBits     = SampleBitsDef;
  localparam int          DrainWait = 60;    // outlasts the full depth of the pipe
  localparam int          IdleLimit = 5000;  // cycles with no beat at all
  localparam longint      GainMax   = (64'sd1 << GainBits) - 1;
  localparam longint      SampMax   = (64'sd1 << (SBits - 1)) - 1;
  localparam longint      SampMin   = -(64'sd1 << (SBits - 1));

  typedef struct {
    logic signed [SBits-1:0] re;
    logic signed [SBits-1:0] im;
    logic                    sat;
  } shaped_t;

  // Compander predictor plus the queue of shaped samples still owed.
  class compander_board;
    logic [ValueBits-1:0] curve[Points];
    bit                   enable;
    shaped_t              owed[$];
    int                   errors, samples, writes, clipped;

    function longint isqrt(longint v);
      longint res;
      res = 0;
      for (int b = 17; b >= 0; b--)
        if ((res | (64'sd1 << b)) * (res | (64'sd1 << b)) <= v) res |= 64'sd1 << b;
      return res;
    endfunction

    // gain is Q5.12; negative products round toward minus infinity
    function longint apply_gain(longint s, longint gain, ref logic sat);
      longint prod, q;
      prod = s * gain;
      q = (prod >= 0) ? prod / 4096 : -((-prod + 4095) / 4096);
      if (q > SampMax) begin
        sat = 1'b1;
        return SampMax;
      end
      if (q < SampMin) begin
        sat = 1'b1;
        return SampMin;
      end
      return q;
    endfunction

    function void note_beat(logic op, logic signed [SBits-1:0] re,
                            logic signed [SBits-1:0] im, logic [IndexBits-1:0] idx,
                            logic [ValueBits-1:0] val);
      shaped_t e;
      longint  m, p, i, r, a, b, y, gain;
      if (op == OP_WRITE) begin
        if (idx < Points) curve[idx] = val;
        writes++;
        return;
      end
      samples++;
      e.re  = re;
      e.im  = im;
      e.sat = 1'b0;
      if (enable) begin
        m = isqrt(longint'(re) * re + longint'(im) * im);
        gain = 0;
        if (m != 0) begin
          p = m * Points;
          i = p >>> (SBits - 1);
          r = p & ((64'sd1 << (SBits - 1)) - 1);
          if (i < Points - 1) begin
            a = curve[i];
            b = curve[i + 1];
            y = a * (64'sd1 << (SBits - 1)) + r * (b - a);
          end else begin
            y = longint'(curve[Points - 1]) * (64'sd1 << (SBits - 1));
          end
          if (y < 0) y = 0;
          gain = y / (8 * m);
          if (gain > GainMax) begin
            gain  = GainMax;
            e.sat = 1'b1;
          end
        end
        e.re = SBits'(apply_gain(re, gain, e.sat));
        e.im = SBits'(apply_gain(im, gain, e.sat));
      end
      owed.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_beat(logic signed [SBits-1:0] re, logic signed [SBits-1:0] im,
                    logic sat);
      shaped_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result re=%0d im=%0d", re, im));
        return;
      end
      e = owed.pop_front();
      if (sat) clipped++;
      if (re !== e.re) report($sformatf("out_re %0d, want %0d", re, e.re));
      if (im !== e.im) report($sformatf("out_im %0d, want %0d", im, e.im));
      if (sat !== e.sat) report($sformatf("saturated %b, want %b", sat, e.sat));
    endtask
  endclass

  logic                    clk, rst_n;
  logic                    push, full, empty, pop;
  logic                    op;
  logic signed [SBits-1:0] s_re, s_im, o_re, o_im;
  logic [IndexBits-1:0]    t_idx;
  logic [ValueBits-1:0]    t_val;
  logic                    o_sat;
  logic                    cfg_valid, cfg_ready, cfg_data;

  compander_board board;
  bit             calm, long_hold;
  int             idle_cycles;

  waveshaping_compander dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .op_i         (op),
    .sample_re_i  (s_re),
    .sample_im_i  (s_im),
    .table_index_i(t_idx),
    .table_value_i(t_val),
    .empty        (empty),
    .pop          (pop),
    .out_re_o     (o_re),
    .out_im_o     (o_im),
    .saturated_o  (o_sat),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: reads the values that stood before the edge, so NBA order
  // within the step does not matter. Also runs the no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) board.note_beat(op, s_re, s_im, t_idx, t_val);
      if (pop && !empty) board.check_beat(o_re, o_im, o_sat);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one beat and hold it until the block takes it. Returns at the
  // accepting edge with push still high.
  task automatic offer(logic o, logic signed [SBits-1:0] re, logic signed [SBits-1:0] im,
                       logic [IndexBits-1:0] idx, logic [ValueBits-1:0] val);
    bit taken;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push  <= 1'b1;
    op    <= o;
    s_re  <= re;
    s_im  <= im;
    t_idx <= idx;
    t_val <= val;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic sample(logic signed [SBits-1:0] re, logic signed [SBits-1:0] im);
    offer(OP_SAMPLE, re, im, IndexBits'($urandom), ValueBits'($urandom));
  endtask

  task automatic table_word(logic [IndexBits-1:0] idx, logic [ValueBits-1:0] val);
    offer(OP_WRITE, SBits'($urandom), SBits'($urandom), idx, val);
  endtask

  // Sender goes quiet until every owed result is back, then lets the pipe
  // settle since table writes leave nothing to wait for.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_enable(bit v);
    bit taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    board.enable = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Small and mid magnitudes half the time, where the table shape matters most.
  task automatic random_sample();
    case ($urandom_range(0, 3))
      0: sample(SBits'($urandom_range(0, 15) - 8), SBits'($urandom_range(0, 15) - 8));
      1: sample(SBits'($urandom_range(0, 2047) - 1024),
                SBits'($urandom_range(0, 2047) - 1024));
      default: sample(SBits'($urandom), SBits'($urandom));
    endcase
  endtask

  task automatic random_value(output logic [ValueBits-1:0] v);
    v = ($urandom_range(0, 15) == 0) ? 16'd32768 : 16'($urandom_range(0, 32767));
  endtask

  task automatic random_stretch(int n, bit rewrites);
    logic [ValueBits-1:0] v;
    for (int k = 0; k < n; k++) begin
      if (rewrites && $urandom_range(0, 5) == 0) begin
        random_value(v);
        table_word(IndexBits'($urandom_range(0, Points - 1)), v);
      end else begin
        random_sample();
      end
    end
  endtask

  // Receiver: random stall bursts, one long hold on request, none when calm.
  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [ValueBits-1:0] v;
    board       = new();
    calm        = 1'b0;
    long_hold   = 1'b0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    push        = 1'b0;
    op          = OP_SAMPLE;
    s_re        = '0;
    s_im        = '0;
    t_idx       = '0;
    t_val       = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every table word: a rising curve with random ripple, top at one.
    for (int k = 0; k < Points; k++) begin
      if (k == Points - 1)      v = 16'd32768;
      else if (k == 0)          v = 16'd0;
      else if (k % 37 == 0)     v = 16'($urandom_range(0, 32767));
      else                      v = 16'(k * 64 + $urandom_range(0, 63));
      table_word(IndexBits'(k), v);
    end

    // Pass through with the enable written low explicitly.
    set_enable(1'b0);
    sample(16'sh7fff, 16'sh8000);
    sample(16'sh5555, 16'shaaaa);
    random_stretch(20, 1'b0);

    // Directed shaping: zero magnitude, extremes, last-entry region, tiny
    // magnitudes that drive the gain into clipping.
    set_enable(1'b1);
    sample(16'sd0, 16'sd0);
    sample(16'sh7fff, 16'sh7fff);
    sample(16'sh8000, 16'sh8000);
    sample(16'sh8000, 16'sd0);
    sample(16'sd0, 16'sh7fff);
    sample(16'sd1, 16'sd0);
    sample(-16'sd1, -16'sd1);
    sample(16'sh5555, 16'shaaaa);
    sample(16'shaaaa, 16'sh5555);
    sample(16'sd64, -16'sd64);
    sample(16'sh4000, 16'sd0);
    table_word(9'd0, 16'd32768);
    table_word(9'd1, 16'd32768);
    sample(16'sd1, 16'sd1);
    sample(-16'sd2, 16'sd3);
    sample(16'sh7fff, 16'sd1);

    random_stretch(150, 1'b1);
    long_hold = 1'b1;  // receiver backs off while samples keep coming
    random_stretch(150, 1'b1);

    set_enable(1'b0);
    random_stretch(80, 1'b1);

    set_enable(1'b1);
    random_stretch(150, 1'b1);
    calm = 1'b1;
    random_stretch(100, 1'b1);

    drain();
    $display("covered %0d samples and %0d table writes, %0d results flagged saturated",
             board.samples, board.writes, board.clipped);
    $display("enable toggled on and off, long receiver hold, %0d mismatches",
             board.errors);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
